### rtl/core/bbc_pkg.sv
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef logic [1:0] kind_t;

    typedef enum logic [1:0] {
        COND_OPEN     = 2'd0,
        COND_CORRUPT  = 2'd1,
        COND_OVERFLOW = 2'd2
    } cond_t;

    typedef enum logic [2:0] {
        ST_PENDING    = 3'd0,
        ST_CORRUPT    = 3'd1,
        ST_BALANCED   = 3'd2,
        ST_INCOMPLETE = 3'd3,
        ST_OVERFLOW   = 3'd4
    } status_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        kind_t kind;
    } stack_op_t;

    localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    function automatic logic [2:0] opener_lookup(input logic [7:0] c);
        logic [2:0] r;
        case (c)
            CH_OPEN_PAREN:  r = 3'b100;
            CH_OPEN_SQUARE: r = 3'b101;
            CH_OPEN_CURLY:  r = 3'b110;
            CH_OPEN_ANGLE:  r = 3'b111;
            default:        r = 3'b000;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] closer_lookup(input logic [7:0] c);
        logic [2:0] r;
        case (c)
            CH_CLOSE_PAREN:  r = 3'b100;
            CH_CLOSE_SQUARE: r = 3'b101;
            CH_CLOSE_CURLY:  r = 3'b110;
            CH_CLOSE_ANGLE:  r = 3'b111;
            default:         r = 3'b000;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] closer_char(input kind_t k);
        logic [7:0] r;
        case (k)
            2'd0:    r = CH_CLOSE_PAREN;
            2'd1:    r = CH_CLOSE_SQUARE;
            2'd2:    r = CH_CLOSE_CURLY;
            default: r = CH_CLOSE_ANGLE;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/bbc_stack.sv
module bbc_stack
    import bbc_pkg::*;
(
    input  logic      clk,
    input  stack_op_t op,
    output kind_t     top
);

    kind_t stk_reg [STACK_DEPTH];

    // The stack shifts as a whole, so the top entry always sits in slot zero.
    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            stk_reg[0] <= op.kind;
            for (int i = 1; i < STACK_DEPTH; i++)
            begin
                stk_reg[i] <= stk_reg[i - 1];
            end
        end
        else if (op.pop)
        begin
            for (int i = 0; i < STACK_DEPTH - 1; i++)
            begin
                stk_reg[i] <= stk_reg[i + 1];
            end
        end
    end

    assign top = stk_reg[0];

endmodule

### rtl/core/bracket_balance_checker.sv
// Bracket balance checker. Characters arrive one word per cycle on the char
// channel (ch, line_end, char_valid, char_stall) while char_stall is low;
// line_end marks the last character of a line. Each accepted word yields
// exactly one result word on the res channel (status, found, expected,
// open_depth, line_done). Openers are pushed on a shift-register stack
// whose top sits in a fixed register, so a new character is taken every
// unstalled cycle. A word passes an input register, where it is checked
// against the stack and line state, and then a result register: res_valid
// rises as the result register loads, throughput one word per cycle while
// res_stall is low. When res_stall holds a result, an empty input register
// still takes one more word; char_stall then rises until the result is
// taken. No result is lost or repeated. Reset clears the line state, the
// stack count and both valid flags; the stack contents need no reset,
// since only entries that have been pushed are ever read. At the end of
// each line the verdict is reported and the line state returns to empty.
module bracket_balance_checker
    import bbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] ch,
    input  logic       line_end,
    input  logic       char_valid,
    output logic       char_stall,
    output logic [2:0] status,
    output logic [7:0] found,
    output logic [7:0] expected,
    output logic [6:0] open_depth,
    output logic       line_done,
    output logic       res_valid,
    input  logic       res_stall
);

    logic             s1_valid_reg;
    logic [7:0]       ch_reg;
    logic             last_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    cond_t            cond_reg;
    cond_t            cond_next;
    kind_t            fcode_reg;
    kind_t            fcode_next;
    logic [2:0]       ecode_reg;
    logic [2:0]       ecode_next;

    logic             res_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    logic [7:0]       found_reg;
    logic [7:0]       found_next;
    logic [7:0]       expected_reg;
    logic [7:0]       expected_next;
    logic [6:0]       depth_reg;
    logic             done_reg;

    logic             adv;
    logic             fire;
    logic             accept;
    logic [2:0]       op_hit;
    logic [2:0]       cl_hit;
    stack_op_t        sop;
    kind_t            top;
    logic [CNT_W-1:0] depth_wide;

    assign adv        = !(res_valid_reg && res_stall);
    assign fire       = s1_valid_reg && adv;
    assign char_stall = s1_valid_reg && !adv;
    assign accept     = char_valid && !char_stall;

    assign op_hit = opener_lookup(ch_reg);
    assign cl_hit = closer_lookup(ch_reg);

    bbc_stack u_stack (
        .clk (clk),
        .op  (sop),
        .top (top)
    );

    always_comb
    begin
        cnt_next   = cnt_reg;
        cond_next  = cond_reg;
        fcode_next = fcode_reg;
        ecode_next = ecode_reg;
        sop        = '{push: 1'b0, pop: 1'b0, kind: op_hit[1:0]};

        if (cond_reg == COND_OPEN)
        begin
            if (op_hit[2])
            begin
                if (cnt_reg < CNT_W'(STACK_DEPTH))
                begin
                    sop.push = fire;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    cond_next = COND_OVERFLOW;
                end
            end
            else if (cl_hit[2])
            begin
                if (cnt_reg == '0)
                begin
                    cond_next  = COND_CORRUPT;
                    fcode_next = cl_hit[1:0];
                    ecode_next = 3'd0;
                end
                else
                begin
                    sop.pop  = fire;
                    cnt_next = cnt_reg - 1'b1;
                    if (top != cl_hit[1:0])
                    begin
                        cond_next  = COND_CORRUPT;
                        fcode_next = cl_hit[1:0];
                        ecode_next = {1'b0, top} + 3'd1;
                    end
                end
            end
        end

        if (cond_next == COND_CORRUPT)
        begin
            status_next = ST_CORRUPT;
        end
        else if (cond_next == COND_OVERFLOW)
        begin
            status_next = ST_OVERFLOW;
        end
        else if (last_reg)
        begin
            status_next = (cnt_next == '0) ? ST_BALANCED : ST_INCOMPLETE;
        end
        else
        begin
            status_next = ST_PENDING;
        end

        if (status_next == ST_CORRUPT)
        begin
            found_next    = closer_char(fcode_next);
            expected_next = (ecode_next != 3'd0) ? closer_char(kind_t'(ecode_next - 3'd1))
                                                 : 8'd0;
        end
        else
        begin
            found_next    = 8'd0;
            expected_next = 8'd0;
        end
    end

    assign depth_wide = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            cond_reg      <= COND_OPEN;
            fcode_reg     <= '0;
            ecode_reg     <= '0;
        end
        else
        begin
            if (adv)
            begin
                res_valid_reg <= s1_valid_reg;
                s1_valid_reg  <= accept;
            end
            else if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            if (fire)
            begin
                if (last_reg)
                begin
                    cnt_reg   <= '0;
                    cond_reg  <= COND_OPEN;
                    fcode_reg <= '0;
                    ecode_reg <= '0;
                end
                else
                begin
                    cnt_reg   <= cnt_next;
                    cond_reg  <= cond_next;
                    fcode_reg <= fcode_next;
                    ecode_reg <= ecode_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= ch;
            last_reg <= line_end;
        end
        if (fire)
        begin
            status_reg   <= status_next;
            found_reg    <= found_next;
            expected_reg <= expected_next;
            depth_reg    <= depth_wide[6:0];
            done_reg     <= last_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign expected   = expected_reg;
    assign open_depth = depth_reg;
    assign line_done  = done_reg;

endmodule

### bench/tb.sv
module tb;
    import bbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS = 570;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        status_t    status;
        logic [7:0] found;
        logic [7:0] expected;
        logic [6:0] depth;
        logic       done;
    } verdict_word_t;

    typedef enum int {
        LINE_CLEAN,
        LINE_BROKEN,
        LINE_CUT,
        LINE_NOISE
    } line_mode_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic [7:0] ch;
    logic       line_end;
    logic       char_valid;
    logic       char_stall;
    logic [2:0] status;
    logic [7:0] found;
    logic [7:0] expected;
    logic [6:0] open_depth;
    logic       line_done;
    logic       res_valid;
    logic       res_stall = 1'b0;

    // Shadow copy of the bracket stack and the line state.
    kind_t nest_kinds [STACK_DEPTH];
    int    nest_count;
    cond_t line_cond;
    kind_t bad_kind;
    logic  have_wanted;
    kind_t wanted_kind;

    verdict_word_t pending_verdicts[$];
    verdict_word_t head;

    bit quiet;
    int stall_left;
    int idle_cycles;
    int words_sent;
    int results_seen;
    int mismatches;
    int line_verdicts [5];

    bracket_balance_checker dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .ch         (ch),
        .line_end   (line_end),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .status     (status),
        .found      (found),
        .expected   (expected),
        .open_depth (open_depth),
        .line_done  (line_done),
        .res_valid  (res_valid),
        .res_stall  (res_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] opener_of(input kind_t k);
        case (k)
            2'd0:    return CH_OPEN_PAREN;
            2'd1:    return CH_OPEN_SQUARE;
            2'd2:    return CH_OPEN_CURLY;
            default: return CH_OPEN_ANGLE;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(input kind_t k);
        case (k)
            2'd0:    return CH_CLOSE_PAREN;
            2'd1:    return CH_CLOSE_SQUARE;
            2'd2:    return CH_CLOSE_CURLY;
            default: return CH_CLOSE_ANGLE;
        endcase
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] filler_char();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic void clear_line_state();
        nest_count = 0;
        line_cond = COND_OPEN;
        bad_kind = 2'd0;
        have_wanted = 1'b0;
        wanted_kind = 2'd0;
    endfunction

    function automatic verdict_word_t judge_char(input logic [7:0] c, input logic last);
        verdict_word_t r;
        logic is_open;
        logic is_close;
        kind_t k;
        is_open = 1'b0;
        is_close = 1'b0;
        k = 2'd0;
        case (c)
            CH_OPEN_PAREN:   begin is_open = 1'b1;  k = 2'd0; end
            CH_OPEN_SQUARE:  begin is_open = 1'b1;  k = 2'd1; end
            CH_OPEN_CURLY:   begin is_open = 1'b1;  k = 2'd2; end
            CH_OPEN_ANGLE:   begin is_open = 1'b1;  k = 2'd3; end
            CH_CLOSE_PAREN:  begin is_close = 1'b1; k = 2'd0; end
            CH_CLOSE_SQUARE: begin is_close = 1'b1; k = 2'd1; end
            CH_CLOSE_CURLY:  begin is_close = 1'b1; k = 2'd2; end
            CH_CLOSE_ANGLE:  begin is_close = 1'b1; k = 2'd3; end
            default:         ;
        endcase
        if (line_cond == COND_OPEN)
        begin
            if (is_open)
            begin
                if (nest_count < STACK_DEPTH)
                begin
                    nest_kinds[nest_count] = k;
                    nest_count++;
                end
                else
                    line_cond = COND_OVERFLOW;
            end
            else if (is_close)
            begin
                if (nest_count == 0)
                begin
                    line_cond = COND_CORRUPT;
                    bad_kind = k;
                    have_wanted = 1'b0;
                end
                else
                begin
                    nest_count--;
                    if (nest_kinds[nest_count] != k)
                    begin
                        line_cond = COND_CORRUPT;
                        bad_kind = k;
                        have_wanted = 1'b1;
                        wanted_kind = nest_kinds[nest_count];
                    end
                end
            end
        end
        if (line_cond == COND_CORRUPT)
            r.status = ST_CORRUPT;
        else if (line_cond == COND_OVERFLOW)
            r.status = ST_OVERFLOW;
        else if (last)
            r.status = (nest_count == 0) ? ST_BALANCED : ST_INCOMPLETE;
        else
            r.status = ST_PENDING;
        r.found = (r.status == ST_CORRUPT) ? closer_of(bad_kind) : 8'h00;
        r.expected = (r.status == ST_CORRUPT && have_wanted) ? closer_of(wanted_kind) : 8'h00;
        r.depth = nest_count[6:0];
        r.done = last;
        if (last)
            clear_line_state();
        return r;
    endfunction

    // Called at a rising edge; returns at the rising edge that takes the word.
    task automatic send_word(input logic [7:0] c, input logic last);
        int gap;
        bit taken;
        gap = gap_len();
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        ch <= c;
        line_end <= last;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !char_stall;
            if (taken)
                pending_verdicts.push_back(judge_char(c, last));
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic send_line(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_word(s[i], i == s.len() - 1);
    endtask

    task automatic send_deep_line(input int n_open, input int n_close);
        kind_t kinds[$];
        kind_t k;
        int i;
        for (i = 0; i < n_open; i++)
        begin
            k = kind_t'($urandom_range(0, 3));
            kinds.push_back(k);
            send_word(opener_of(k), 1'b0);
        end
        for (i = 0; i < n_close; i++)
        begin
            if (kinds.size() > 0)
                send_word(closer_of(kinds.pop_back()), 1'b0);
            else
                send_word(closer_of(kind_t'($urandom_range(0, 3))), 1'b0);
        end
        send_word(filler_char(), 1'b1);
    endtask

    task automatic send_random_line(input line_mode_t mode);
        kind_t kinds[$];
        logic [7:0] chars[$];
        kind_t k;
        int len;
        int max_nest;
        int pick;
        int i;
        len = $urandom_range(1, 24);
        max_nest = $urandom_range(1, 8);
        for (i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 9);
            if (mode == LINE_NOISE)
                chars.push_back(8'($urandom_range(0, 255)));
            else if (pick < 4 && kinds.size() < max_nest)
            begin
                k = kind_t'($urandom_range(0, 3));
                kinds.push_back(k);
                chars.push_back(opener_of(k));
            end
            else if (pick < 7 && kinds.size() > 0)
            begin
                k = kinds.pop_back();
                if (mode == LINE_BROKEN && $urandom_range(0, 4) == 0)
                    k = kind_t'(k + $urandom_range(1, 3));
                chars.push_back(closer_of(k));
            end
            else if (mode == LINE_BROKEN && pick == 7)
                chars.push_back(closer_of(kind_t'($urandom_range(0, 3))));
            else
                chars.push_back(filler_char());
        end
        if (mode != LINE_CUT && mode != LINE_NOISE)
            while (kinds.size() > 0)
                chars.push_back(closer_of(kinds.pop_back()));
        for (i = 0; i < chars.size(); i++)
            send_word(chars[i], i == chars.size() - 1);
    endtask

    task automatic test_directed();
        send_line("([{<>}])");
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        send_line(")");
        send_line("(]");
        send_line("{(>((");
        send_line("<<");
    endtask

    task automatic test_depth_limit();
        send_deep_line(STACK_DEPTH, STACK_DEPTH);
        send_deep_line(STACK_DEPTH, 0);
        send_deep_line(STACK_DEPTH + 1, 3);
        send_deep_line(STACK_DEPTH + 6, STACK_DEPTH + 6);
    endtask

    task automatic test_random_lines();
        int stop_at;
        int r;
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at)
        begin
            quiet = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 55)
                send_random_line(LINE_CLEAN);
            else if (r < 75)
                send_random_line(LINE_BROKEN);
            else if (r < 87)
                send_random_line(LINE_CUT);
            else if (r < 96)
                send_random_line(LINE_NOISE);
            else
                send_deep_line($urandom_range(40, STACK_DEPTH + 6), $urandom_range(0, 70));
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || quiet)
        begin
            stall_left = 0;
            res_stall <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
                stall_left = gap_len();
            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // Outputs are sampled at the falling edge; inputs only move at the rising edge.
    always @(negedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (line_done && status <= ST_OVERFLOW)
                line_verdicts[status]++;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result word %0d arrived with nothing expected: status %0d",
                             results_seen, status);
            end
            else
            begin
                head = pending_verdicts.pop_front();
                if (head.status !== status || head.found !== found ||
                    head.expected !== expected || head.depth !== open_depth ||
                    head.done !== line_done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Result word %0d mismatch: expected status %0d found %h ",
                                  "expected %h depth %0d done %b, got %0d %h %h %0d %b"},
                                 results_seen, head.status, head.found, head.expected,
                                 head.depth, head.done, status, found, expected,
                                 open_depth, line_done);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && !char_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("No word moved for %0d cycles, %0d results outstanding.",
                         idle_cycles, pending_verdicts.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        ch = 8'h00;
        line_end = 1'b0;
        char_valid = 1'b0;
        rst_n = 1'b0;
        quiet = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        words_sent = 0;
        results_seen = 0;
        mismatches = 0;
        line_verdicts = '{default: 0};
        clear_line_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_depth_limit();
        test_random_lines();

        char_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d characters and checked %0d result words.", words_sent, results_seen);
        $display("Lines: %0d balanced, %0d incomplete, %0d corrupt, %0d overflow.",
                 line_verdicts[ST_BALANCED], line_verdicts[ST_INCOMPLETE],
                 line_verdicts[ST_CORRUPT], line_verdicts[ST_OVERFLOW]);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
